### rtl/core/prmb_pkg.sv
// shared constants and codes for the page range mark bitmap
`default_nettype none

package prmb_pkg;

  // default geometry of the byte address space and pages
  localparam int unsigned ADDR_BITS_DEF = 32;
  localparam int unsigned PAGE_BITS_DEF = 12;

  // bitmap word geometry
  localparam int unsigned WORD_BITS     = 32;
  localparam int unsigned WORD_SEL_BITS = 5;
  localparam int unsigned CHUNK_BITS    = 32;

  // request codes
  typedef enum logic [1:0] {
    ACT_MARK   = 2'd0,
    ACT_UNMARK = 2'd1,
    ACT_TEST   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

endpackage : prmb_pkg

`default_nettype wire

### rtl/core/page_range_mark_bitmap.sv
// page range mark bitmap: one mark bit per page with a chunk commit map
`default_nettype none

// Keeps one mark bit per page of the byte address space in a bitmap memory of
// 32-bit words, plus a 32-bit map of committed bitmap chunks.
// Input: a beat is taken at a rising edge with start high and busy low. It
// carries an action (mark, unmark, test), a start byte address and a byte
// length. Ranges past the top of the address space are clipped.
// Output: exactly one result beat per request, shown on out_any_marked with
// out_valid high for one cycle. The receiver cannot stall the block.
// Sequence: a setup step and a range step, then a read step and a check step
// per bitmap word the range covers (the check tests the word or writes it
// back modified through the write port, beside the one read port); a test
// stops at the first word with a marked page. Zero length, the unused action
// code or a start above the top answer from the range step.
// Busy stays high until the result beat, so one request runs at a time.
// Reset: a clearing pass writes zero to every bitmap word, one word per
// cycle, 2^(ADDR_BITS-PAGE_BITS-5) words (32768 at the defaults), with busy
// high; the commit map clears at once.
module page_range_mark_bitmap #(
  parameter int unsigned ADDR_BITS = prmb_pkg::ADDR_BITS_DEF,
  parameter int unsigned PAGE_BITS = prmb_pkg::PAGE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_action,
  input  wire logic [31:0] in_start_address,
  input  wire logic [31:0] in_length,
  output logic             out_valid,
  output logic             out_any_marked
);

  // geometry
  localparam int unsigned PN_BITS   = ADDR_BITS - PAGE_BITS;
  localparam int unsigned WIDX      = (PN_BITS > prmb_pkg::WORD_SEL_BITS + 1) ?
                                      (PN_BITS - prmb_pkg::WORD_SEL_BITS) : 1;
  localparam int unsigned DEPTH     = 1 << WIDX;
  localparam int unsigned CHUNK_SH  = PAGE_BITS - 2;
  localparam logic [32:0] ADDR_TOP  = (33'd1 << ADDR_BITS) - 33'd1;
  localparam logic [31:0] CHUNK_MAX = 32'(prmb_pkg::CHUNK_BITS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_RANGE,
    ST_READ,
    ST_CHECK
  } state_t;

  state_t             state_r;
  logic [WIDX-1:0]    clr_r;
  prmb_pkg::action_t  action_r;
  logic [31:0]        start_r;
  logic [31:0]        len_r;
  logic [32:0]        last_r;
  logic [WIDX-1:0]    word_r;
  logic [WIDX-1:0]    last_word_r;
  logic [WIDX-1:0]    first_word_r;
  logic [4:0]         lo_r;
  logic [4:0]         hi_r;
  logic [31:0]        committed_r;
  logic               out_valid_r;
  logic               any_r;

  // bitmap memory
  logic [31:0]        mem [DEPTH];
  logic [31:0]        rdata_r;
  logic               mem_we;
  logic [WIDX-1:0]    mem_waddr;
  logic [31:0]        mem_wdata;

  // range bounds derived in the range step
  logic [32:0]        last_clip;
  logic [31:0]        first_page;
  logic [31:0]        last_page;

  // per-word mask, chunk bit and updated word
  logic [4:0]         lo_cur;
  logic [4:0]         hi_cur;
  logic [31:0]        mask;
  logic [31:0]        chunk_sh32;
  logic [4:0]         chunk_idx;
  logic [31:0]        chunk_bit;
  logic               hit;
  logic               last_word;
  logic [31:0]        new_word;

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_any_marked = any_r;

  // range bounds
  always_comb begin
    last_clip  = (last_r > ADDR_TOP) ? ADDR_TOP : last_r;
    first_page = start_r >> PAGE_BITS;
    last_page  = last_clip[31:0] >> PAGE_BITS;
  end

  // mask and chunk for the word in flight
  always_comb begin
    lo_cur     = (word_r == first_word_r) ? lo_r : 5'd0;
    last_word  = (word_r == last_word_r);
    hi_cur     = last_word ? hi_r : 5'd31;
    mask       = (32'hFFFF_FFFF >> (5'd31 - hi_cur)) & (32'hFFFF_FFFF << lo_cur);
    chunk_sh32 = 32'(word_r) >> CHUNK_SH;
    chunk_idx  = (chunk_sh32 > CHUNK_MAX) ? CHUNK_MAX[4:0] : chunk_sh32[4:0];
    chunk_bit  = 32'd1 << chunk_idx;
    hit        = ((committed_r & chunk_bit) != 32'd0) && ((rdata_r & mask) != 32'd0);
    new_word   = (action_r == prmb_pkg::ACT_MARK) ? (rdata_r | mask) : (rdata_r & ~mask);
  end

  // memory write port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = word_r;
    mem_wdata = new_word;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = 32'd0;
      end
      ST_CHECK: begin
        mem_we = (action_r == prmb_pkg::ACT_MARK) || (action_r == prmb_pkg::ACT_UNMARK);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // bitmap memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[word_r];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      committed_r <= '0;
      out_valid_r <= 1'b0;
      any_r       <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        // zero every bitmap word after reset
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == WIDX'(DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        // take a request beat
        ST_IDLE: begin
          if (start) begin
            action_r <= prmb_pkg::action_t'(in_action);
            start_r  <= in_start_address;
            len_r    <= in_length;
            state_r  <= ST_SETUP;
          end
        end
        // last byte of the range
        ST_SETUP: begin
          last_r  <= {1'b0, start_r} + {1'b0, len_r} - 33'd1;
          state_r <= ST_RANGE;
        end
        // word bounds and edge bits, or an immediate answer for a no-op
        ST_RANGE: begin
          if (len_r == 32'd0 || action_r == prmb_pkg::ACT_NONE ||
              {1'b0, start_r} > ADDR_TOP) begin
            out_valid_r <= 1'b1;
            any_r       <= 1'b0;
            state_r     <= ST_IDLE;
          end else begin
            first_word_r <= WIDX'(first_page >> prmb_pkg::WORD_SEL_BITS);
            word_r       <= WIDX'(first_page >> prmb_pkg::WORD_SEL_BITS);
            last_word_r  <= WIDX'(last_page >> prmb_pkg::WORD_SEL_BITS);
            lo_r         <= first_page[4:0];
            hi_r         <= last_page[4:0];
            state_r      <= ST_READ;
          end
        end
        // memory read of the current word
        ST_READ: begin
          state_r <= ST_CHECK;
        end
        // test or read-modify-write, then advance
        ST_CHECK: begin
          if (action_r == prmb_pkg::ACT_TEST) begin
            if (hit || last_word) begin
              out_valid_r <= 1'b1;
              any_r       <= hit;
              state_r     <= ST_IDLE;
            end else begin
              word_r  <= word_r + 1'b1;
              state_r <= ST_READ;
            end
          end else begin
            committed_r <= committed_r | chunk_bit;
            if (last_word) begin
              out_valid_r <= 1'b1;
              any_r       <= 1'b0;
              state_r     <= ST_IDLE;
            end else begin
              word_r  <= word_r + 1'b1;
              state_r <= ST_READ;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule : page_range_mark_bitmap

`default_nettype wire
